// ===== rtl/bpc_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation pipeline.
// No dependencies.
package bpc_pkg;

  localparam int DIV_W   = 32;
  localparam int DIV_LAT = DIV_W;

  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;

  localparam logic [31:0] K_B6_OFS  = 32'd4000;
  localparam logic [31:0] K_B7_MUL  = 32'd50000;
  localparam logic [31:0] K_B4_OFS  = 32'd32768;
  localparam logic [31:0] K_P_SQ    = 32'd3038;
  localparam logic [31:0] K_P_LIN   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_P_OFS   = 32'd3791;

  typedef struct packed {
    logic        v;
    logic [31:0] x1;
    logic        neg;
    logic        err;
    logic [15:0] up;
  } sd1_t;

  typedef struct packed {
    logic        v;
    logic [31:0] t;
    logic        err;
    logic        b7_low;
  } sd2_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

// ===== rtl/baro_temp_pressure_compensation_top.sv =====
// Top level of the barometric temperature/pressure compensation pipeline.
// Depends on bpc_pkg and bpc_div.
//
// Usage:
//  - Input stream s_*: one request per cycle unless stalled, each carrying a
//    raw temperature and a raw pressure. Output m_*: one compensated result each.
//  - Config channel cfg_*: index 0..2 selects cal word A, B, C; always ready.
//    Write only while the pipeline is empty.
//  - Depth: 81 register stages from the accepting edge to m_tvalid. Two
//    32-stage dividers (one bit per stage) set most of that, plus 17
//    arithmetic stages.
//  - Throughput: one request per cycle while the output is taken.
//  - Stall: the whole pipeline holds while m_tvalid is high and m_tready
//    low; s_tready drops in the same cycle. Nothing is lost or repeated.
//  - A zero divisor gives divide_error = 1 with both results zero.
//  - Reset (rst, synchronous) clears all valid bits and the cal words.
module baro_temp_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] raw_temperature, [31:16] raw_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] true_temperature, [63:32] true_pressure
  output logic        m_tuser,   // [0] divide_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic        en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAL_A: cal_a <= cfg_data;
        REG_CAL_B: cal_b <= cfg_data;
        REG_CAL_C: cal_c <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_a[63:48]);
  assign ac2 = sx16(cal_a[47:32]);
  assign ac3 = sx16(cal_a[31:16]);
  assign ac4 = {16'd0, cal_a[15:0]};
  assign ac5 = {16'd0, cal_b[63:48]};
  assign ac6 = {16'd0, cal_b[47:32]};
  assign b1  = sx16(cal_b[31:16]);
  assign b2  = sx16(cal_b[15:0]);
  assign mc  = sx16(cal_c[31:16]);
  assign md  = sx16(cal_c[15:0]);

  // valid bits
  logic va, vb, vc, vd, ve, vf, vg, vh, vi, vj, vk, vl, vm, vn, vo, vp;

  // temperature front end
  logic [31:0] a_prod, b_x1, b_den, c_ma, c_md, c_x1;
  logic [15:0] a_up, b_up, c_up;
  logic        c_neg, c_err;
  logic [31:0] num1, mag_num1;

  assign num1     = mc << 11;
  assign mag_num1 = num1[31] ? 32'(-num1) : num1;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= 32'(({16'd0, s_tdata[15:0]} - ac6) * ac5);
      a_up   <= s_tdata[31:16];
      b_x1   <= asr(a_prod, 15);
      b_den  <= asr(a_prod, 15) + md;
      b_up   <= a_up;
      c_ma   <= mag_num1;
      c_md   <= b_den[31] ? 32'(-b_den) : b_den;
      c_neg  <= num1[31] ^ b_den[31];
      c_err  <= b_den == 32'd0;
      c_x1   <= b_x1;
      c_up   <= b_up;
    end
  end

  logic [31:0] q1, q2;
  sd1_t        s1q [DIV_LAT];
  sd2_t        s2q [DIV_LAT];
  sd1_t        s1o;
  sd2_t        s2o;

  bpc_div u_div_t (.clk(clk), .en(en), .num(c_ma), .den(c_md), .quo(q1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) s1q[i].v <= 1'b0;
    end else if (en) begin
      s1q[0] <= '{v: vc, x1: c_x1, neg: c_neg, err: c_err, up: c_up};
      for (int i = 1; i < DIV_LAT; i++) s1q[i] <= s1q[i-1];
    end
  end
  assign s1o = s1q[DIV_LAT-1];

  // temperature result and pressure coefficients
  logic [31:0] x2t, d_b5;
  logic [31:0] d_t, d_b6;
  logic        d_err;
  logic [15:0] d_up;
  logic [31:0] e_sqp, e_a2, e_a3, e_t;
  logic        e_err;
  logic [15:0] e_up;
  logic [31:0] f_sq, f_x2, f_x1c, f_t;
  logic        f_err;
  logic [15:0] f_up;
  logic [31:0] g_b2sq, g_b1sq, g_x2, g_x1c, g_t;
  logic        g_err;
  logic [15:0] g_up;
  logic [31:0] h_x3, h_x3c, h_t;
  logic        h_err;
  logic [15:0] h_up;
  logic [31:0] i_bn, i_tmp, i_t;
  logic        i_err;
  logic [15:0] i_up;
  logic [31:0] j_b3, j_b4p, j_t;
  logic        j_err;
  logic [15:0] j_up;
  logic [31:0] k_b4, k_diff, k_t;
  logic        k_err;
  logic [31:0] l_b7, l_b4, l_t;
  logic        l_err;
  logic [31:0] m_num, m_den, m_t;
  logic        m_err, m_b7_low;

  assign x2t  = s1o.neg ? 32'(-q1) : q1;
  assign d_b5 = s1o.x1 + x2t;

  always_ff @(posedge clk) begin
    if (rst) begin
      {vd, ve, vf, vg, vh, vi, vj, vk, vl, vm} <= '0;
    end else if (en) begin
      {vd, ve, vf, vg, vh, vi, vj, vk, vl, vm} <=
        {s1o.v, vd, ve, vf, vg, vh, vi, vj, vk, vl};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_t    <= asr(d_b5 + 32'd8, 4);
      d_b6   <= d_b5 - K_B6_OFS;
      d_err  <= s1o.err;
      d_up   <= s1o.up;

      e_sqp  <= 32'(d_b6 * d_b6);
      e_a2   <= 32'(ac2 * d_b6);
      e_a3   <= 32'(ac3 * d_b6);
      e_t    <= d_t;
      e_err  <= d_err;
      e_up   <= d_up;

      f_sq   <= asr(e_sqp, 12);
      f_x2   <= asr(e_a2, 11);
      f_x1c  <= asr(e_a3, 13);
      f_t    <= e_t;
      f_err  <= e_err;
      f_up   <= e_up;

      g_b2sq <= 32'(b2 * f_sq);
      g_b1sq <= 32'(b1 * f_sq);
      g_x2   <= f_x2;
      g_x1c  <= f_x1c;
      g_t    <= f_t;
      g_err  <= f_err;
      g_up   <= f_up;

      h_x3   <= asr(g_b2sq, 11) + g_x2;
      h_x3c  <= asr(g_x1c + asr(g_b1sq, 16) + 32'd2, 2);
      h_t    <= g_t;
      h_err  <= g_err;
      h_up   <= g_up;

      i_bn   <= (ac1 << 2) + h_x3 + 32'd2;
      i_tmp  <= h_x3c + K_B4_OFS;
      i_t    <= h_t;
      i_err  <= h_err;
      i_up   <= h_up;

      // divide by 4 truncating toward zero
      j_b3   <= asr(i_bn + (i_bn[31] ? 32'd3 : 32'd0), 2);
      j_b4p  <= 32'(ac4 * i_tmp);
      j_t    <= i_t;
      j_err  <= i_err;
      j_up   <= i_up;

      k_b4   <= j_b4p >> 15;
      k_diff <= {16'd0, j_up} - j_b3;
      k_t    <= j_t;
      k_err  <= j_err;

      l_b7   <= 32'(k_diff * K_B7_MUL);
      l_b4   <= k_b4;
      l_t    <= k_t;
      l_err  <= k_err || (k_b4 == 32'd0);

      m_b7_low <= !l_b7[31];
      m_num    <= l_b7[31] ? l_b7 : (l_b7 << 1);
      m_den    <= l_b4;
      m_t      <= l_t;
      m_err    <= l_err;
    end
  end

  bpc_div u_div_p (.clk(clk), .en(en), .num(m_num), .den(m_den), .quo(q2));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) s2q[i].v <= 1'b0;
    end else if (en) begin
      s2q[0] <= '{v: vm, t: m_t, err: m_err, b7_low: m_b7_low};
      for (int i = 1; i < DIV_LAT; i++) s2q[i] <= s2q[i-1];
    end
  end
  assign s2o = s2q[DIV_LAT-1];

  // pressure back end
  logic [31:0] n_p, n_t, o_sq, o_m, o_p, o_t, p_x1p, p_x2, p_p, p_t;
  logic        n_err, o_err, p_err;
  logic [31:0] out_t, out_p, sp, fin_p;
  logic        out_err;

  assign sp    = asr(n_p, 8);
  assign fin_p = p_p + asr(asr(p_x1p, 16) + p_x2 + K_P_OFS, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      {vn, vo, vp, m_tvalid} <= '0;
    end else if (en) begin
      {vn, vo, vp, m_tvalid} <= {s2o.v, vn, vo, vp};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p   <= s2o.b7_low ? q2 : (q2 << 1);
      n_t   <= s2o.t;
      n_err <= s2o.err;

      o_sq  <= 32'(sp * sp);
      o_m   <= 32'(K_P_LIN * n_p);
      o_p   <= n_p;
      o_t   <= n_t;
      o_err <= n_err;

      p_x1p <= 32'(o_sq * K_P_SQ);
      p_x2  <= asr(o_m, 16);
      p_p   <= o_p;
      p_t   <= o_t;
      p_err <= o_err;

      out_t   <= p_err ? 32'd0 : p_t;
      out_p   <= p_err ? 32'd0 : fin_p;
      out_err <= p_err;
    end
  end

  assign m_tdata = {out_p, out_t};
  assign m_tuser = out_err;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 64'd0)
    else $error("error result carries nonzero data");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow pipeline enable");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vp) && $stable(s2o.v))
    else $error("pipeline moved during output stall");

endmodule

// ===== rtl/bpc_div.sv =====
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bpc_pkg.
module bpc_div
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] nr [DIV_LAT+1];
  logic [DIV_W-1:0] dr [DIV_LAT+1];
  logic [DIV_W-1:0] rr [DIV_LAT+1];
  logic [DIV_W-1:0] qr [DIV_LAT+1];

  assign nr[0] = num;
  assign dr[0] = den;
  assign rr[0] = '0;
  assign qr[0] = '0;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DIV_W:0]   rs;
    logic [DIV_W:0]   diff;
    logic             ge;
    always_comb begin
      rs   = {rr[k], nr[k][DIV_W-1]};
      diff = rs - {1'b0, dr[k]};
      ge   = rs >= {1'b0, dr[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nr[k+1] <= {nr[k][DIV_W-2:0], 1'b0};
        dr[k+1] <= dr[k];
        rr[k+1] <= ge ? diff[DIV_W-1:0] : rs[DIV_W-1:0];
        qr[k+1] <= {qr[k][DIV_W-2:0], ge};
      end
    end
  end

  assign quo = qr[DIV_LAT];

endmodule

// ===== test/tb.sv =====
// Testbench for baro_temp_pressure_compensation_top: drives raw reading pairs and
// calibration writes, predicts each compensated result and checks it in order.
// Depends on bpc_pkg and the RTL of the compensation pipeline.
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 120;

  typedef enum logic [1:0] {REQ_READING, REQ_CAL, REQ_DRAIN, REQ_IDLING} req_kind_e;

  typedef struct {
    req_kind_e   kind;
    logic [15:0] ut;
    logic [15:0] up;
    logic [1:0]  idx;
    logic [63:0] data;
    int          src_pct;
    int          dst_pct;
  } request_t;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        div_err;
  } reading_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] raw_temperature, [31:16] raw_pressure
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;        // [31:0] true_temperature, [63:32] true_pressure
  logic        m_tuser;        // [0] divide_error
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  baro_temp_pressure_compensation_top uut (.*);

  always #5 clk = ~clk;

  request_t pending[$];
  reading_t expected_readings[$];
  logic [63:0] cal_a = '0, cal_b = '0;
  logic [31:0] cal_c = '0;
  logic s_taken = 0, cfg_taken = 0;
  int src_idle_pct = 0, dst_idle_pct = 0;
  int n_fail = 0, n_readings = 0, n_results = 0, n_div_err = 0, n_cal = 0;
  int quiet_cycles = 0;

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] d);
    return 32'($signed(a) / $signed(d));
  endfunction

  function automatic reading_t compensate(input logic [15:0] ut, input logic [15:0] up);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, den, sq;
    reading_t r;
    r = '{temp: '0, pres: '0, div_err: 1'b1};
    ac1 = ext16(cal_a[63:48]);
    ac2 = ext16(cal_a[47:32]);
    ac3 = ext16(cal_a[31:16]);
    ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]};
    ac6 = {16'd0, cal_b[47:32]};
    b1  = ext16(cal_b[31:16]);
    b2  = ext16(cal_b[15:0]);
    mc  = ext16(cal_c[31:16]);
    md  = ext16(cal_c[15:0]);
    x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = sdiv(mc << 11, den);
    b5 = x1 + x2;
    r.temp = sra(b5 + 32'd8, 4);
    b6 = b5 - K_B6_OFS;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sdiv(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + K_B4_OFS)) >> 15;
    if (b4 == 0) begin
      r.temp = '0;
      return r;
    end
    b7 = ({16'd0, up} - b3) * K_B7_MUL;
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * K_P_SQ, 16);
    x2 = sra(K_P_LIN * p, 16);
    r.pres = p + sra(x1 + x2 + K_P_OFS, 4);
    r.div_err = 1'b0;
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
    n_fail++;
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      s_taken <= 0;
      cfg_taken <= 0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        n_cal++;
        case (cfg_index)
          REG_CAL_A: cal_a = cfg_data;
          REG_CAL_B: cal_b = cfg_data;
          REG_CAL_C: cal_c = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_readings.push_back(compensate(s_tdata[15:0], s_tdata[31:16]));
        n_readings++;
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_readings.size() == 0) begin
          $display("unexpected result at %0t", $time);
          n_fail++;
        end else begin
          want = expected_readings.pop_front();
          if (want.div_err) n_div_err++;
          if (m_tdata[31:0] !== want.temp) report("true_temperature", m_tdata[31:0], want.temp);
          if (m_tdata[63:32] !== want.pres) report("true_pressure", m_tdata[63:32], want.pres);
          if (m_tuser !== want.div_err)
            report("divide_error", {31'd0, m_tuser}, {31'd0, want.div_err});
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    request_t r;
    logic busy_s, busy_c, nv, nc;
    busy_s = s_tvalid && !s_taken;
    busy_c = cfg_valid && !cfg_taken;
    nv = busy_s;
    nc = busy_c;
    if (!rst && !busy_s && !busy_c && pending.size() > 0) begin
      r = pending[0];
      case (r.kind)
        REQ_READING: begin
          if ($urandom_range(99) >= src_idle_pct) begin
            void'(pending.pop_front());
            nv = 1;
            s_tdata <= {r.up, r.ut};
          end
        end
        REQ_CAL: begin
          if (expected_readings.size() == 0 && !s_tvalid) begin
            void'(pending.pop_front());
            nc = 1;
            cfg_index <= r.idx;
            cfg_data <= r.data;
          end
        end
        REQ_DRAIN: if (expected_readings.size() == 0) void'(pending.pop_front());
        REQ_IDLING: begin
          void'(pending.pop_front());
          src_idle_pct = r.src_pct;
          dst_idle_pct = r.dst_pct;
        end
      endcase
    end
    s_tvalid <= nv;
    cfg_valid <= nc;
    m_tready <= !rst && ($urandom_range(99) >= dst_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (s_tvalid && s_tready || m_tvalid && m_tready || cfg_valid && cfg_ready || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_reading(input logic [15:0] ut, input logic [15:0] up);
    request_t r;
    r = '{kind: REQ_READING, ut: ut, up: up, idx: 0, data: 0, src_pct: 0, dst_pct: 0};
    pending.push_back(r);
  endtask

  task automatic add_cal(input logic [1:0] idx, input logic [63:0] data);
    request_t r;
    r = '{kind: REQ_CAL, ut: 0, up: 0, idx: idx, data: data, src_pct: 0, dst_pct: 0};
    pending.push_back(r);
  endtask

  task automatic add_cal_set(input logic [63:0] a, input logic [63:0] b, input logic [31:0] c);
    add_cal(REG_CAL_A, a);
    add_cal(REG_CAL_B, b);
    add_cal(REG_CAL_C, {32'd0, c});
  endtask

  task automatic add_drain();
    request_t r;
    r = '{kind: REQ_DRAIN, ut: 0, up: 0, idx: 0, data: 0, src_pct: 0, dst_pct: 0};
    pending.push_back(r);
  endtask

  task automatic add_idling(input int src, input int dst);
    request_t r;
    r = '{kind: REQ_IDLING, ut: 0, up: 0, idx: 0, data: 0, src_pct: src, dst_pct: dst};
    pending.push_back(r);
  endtask

  // typical factory calibration
  localparam logic [63:0] CAL_A_TYP = {16'd408, 16'hFFB8, 16'hC7D1, 16'h7FE5};
  localparam logic [63:0] CAL_B_TYP = {16'h7FF5, 16'h5A71, 16'h182E, 16'h0004};
  localparam logic [31:0] CAL_C_TYP = {16'hDDF9, 16'h0B34};

  function automatic logic [15:0] jitter(input logic [15:0] v);
    return v + 16'($urandom_range(400)) - 16'd200;
  endfunction

  initial begin
    logic [63:0] a, b;
    logic [31:0] c;
    add_idling(13, 64);
    // directed: typical calibration and field extremes
    add_cal_set(CAL_A_TYP, CAL_B_TYP, CAL_C_TYP);
    add_reading(16'd27898, 16'd23843);
    add_reading(16'h0000, 16'h0000);
    add_reading(16'hFFFF, 16'hFFFF);
    add_reading(16'h8000, 16'h7FFF);
    add_reading(16'h7FFF, 16'h8000);
    add_reading(16'hFFFF, 16'h0000);
    add_reading(16'h0000, 16'hFFFF);
    add_cal(REG_SPARE, 64'hDEAD_BEEF_0123_4567);  // ignored index
    add_reading(16'd27898, 16'd23843);
    // temperature divisor zero: all calibration cleared
    add_cal_set('0, '0, '0);
    add_reading(16'd27898, 16'd23843);
    add_reading(16'hFFFF, 16'h1234);
    // pressure divisor zero: AC4 cleared
    add_cal_set({CAL_A_TYP[63:16], 16'd0}, CAL_B_TYP, CAL_C_TYP);
    add_reading(16'd27898, 16'd23843);
    add_reading(16'd30000, 16'd40000);
    // extreme calibration words, wrap-around everywhere
    add_cal_set('1, '1, '1);
    add_reading(16'd0, 16'hFFFF);
    add_reading(16'hFFFF, 16'd0);
    add_cal_set({4{16'h8000}}, {4{16'h8000}}, {2{16'h8000}});
    add_reading(16'h1234, 16'h8765);
    add_reading(16'hFFFF, 16'hFFFF);
    add_cal_set({4{16'h7FFF}}, {4{16'h7FFF}}, {2{16'h7FFF}});
    add_reading(16'h0001, 16'hFFFE);
    add_reading(16'h8001, 16'h0001);
    add_drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) add_idling(64, 13);
      if (ph == 8) add_idling(0, 0);
      if (ph % 3 == 2) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = $urandom;
      end else begin
        a = {jitter(CAL_A_TYP[63:48]), jitter(CAL_A_TYP[47:32]),
             jitter(CAL_A_TYP[31:16]), jitter(CAL_A_TYP[15:0])};
        b = {jitter(CAL_B_TYP[63:48]), jitter(CAL_B_TYP[47:32]),
             jitter(CAL_B_TYP[31:16]), jitter(CAL_B_TYP[15:0])};
        c = {jitter(CAL_C_TYP[31:16]), jitter(CAL_C_TYP[15:0])};
      end
      add_cal_set(a, b, c);
      for (int i = 0; i < 106; i++) begin
        if (i == 50 && ph == 1) add_drain();
        if ($urandom_range(3) == 0)
          add_reading(16'($urandom), 16'($urandom));
        else
          add_reading(16'($urandom_range(34000, 22000)), 16'($urandom_range(42000, 14000)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
    while (pending.size() > 0 || s_tvalid || cfg_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d reading pairs, %0d results (%0d with divide error), %0d cal writes",
             n_readings, n_results, n_div_err, n_cal);
    $display("across typical, cleared, extreme and random calibration under three idling mixes");
    if (n_fail == 0 && expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/baro_temp_pressure_compensation_top.sv
test/tb.sv
